/* sv/sha_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial hash values, word types and the front/back queue
// entry shared by the hasher modules.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned DIGEST_WORDS = 8;
	localparam int unsigned ROUNDS = 64;
	localparam int unsigned BYTE_TOTAL_W = 61;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef logic [WORD_W-1:0] word_t;

	// Entry handed from the front part to the compression engine
	typedef struct packed {
		word_t w;
		logic  compress;   // block is full after this word
		logic  finish;     // hash done: emit digest and restart
	} qent_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_PAD,
		FE_LEN_HI,
		FE_LEN_LO
	} fe_state_t;

	typedef enum logic [1:0] {
		BE_FILL,
		BE_ROUND,
		BE_UPDATE,
		BE_EMIT
	} be_state_t;

	function automatic word_t init_h(input logic [2:0] i);
		word_t r;
		unique case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

endpackage

/* sv/sha_msg_if.sv */
// ----------------------------------------------------------------------------
// Message word channel
// Valid/ready channel carrying one message word with byte count and last mark.
// ----------------------------------------------------------------------------
interface sha_msg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  bytes_valid;
	logic        last_word;

	modport source (output valid, data_word, bytes_valid, last_word, input ready);
	modport sink (input valid, data_word, bytes_valid, last_word, output ready);
endinterface

/* sv/sha_dig_if.sv */
// ----------------------------------------------------------------------------
// Digest word channel
// Valid/ready channel carrying one digest word with its index and last mark.
// ----------------------------------------------------------------------------
interface sha_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_digest;

	modport source (output valid, digest_word, word_index, last_digest, input ready);
	modport sink (input valid, digest_word, word_index, last_digest, output ready);
endinterface

/* sv/sha_front.sv */
// ----------------------------------------------------------------------------
// SHA-256 front part
// Accepts message words, counts bytes and words, inserts padding, zero fill
// and the bit length, and pushes block words into the queue.
// ----------------------------------------------------------------------------
module sha_front (
	input  logic         clk,
	input  logic         arst_n,
	sha_msg_if.sink      msg,
	output sha_pkg::qent_t q_data,
	output logic         q_push,
	input  logic         q_full
);
	import sha_pkg::*;

	fe_state_t state_q, state_d;
	logic [BYTE_TOTAL_W-1:0] bytes_q;
	logic [3:0] fill_q;
	logic       two_q;     // extra padding word (full last word) still pending
	logic [2:0] nb;
	logic [BYTE_TOTAL_W-1:0] bytes_new;
	logic [63:0] bits;
	word_t keep, last_w, w;
	logic  fin;

	// Saturate the byte count of a last word
	always_comb begin
		if (!msg.last_word) nb = 3'd4;
		else if (msg.bytes_valid > 3'd4) nb = 3'd4;
		else nb = msg.bytes_valid;
	end

	assign bytes_new = bytes_q + BYTE_TOTAL_W'(nb);
	assign bits = {bytes_q, 3'b000};

	always_comb begin
		keep = '0;
		last_w = '0;
		unique case (nb)
			3'd0: last_w = {PAD_BYTE, 24'h0};
			3'd1: begin keep = 32'hff000000; last_w = {8'h0, PAD_BYTE, 16'h0}; end
			3'd2: begin keep = 32'hffff0000; last_w = {16'h0, PAD_BYTE, 8'h0}; end
			3'd3: begin keep = 32'hffffff00; last_w = {24'h0, PAD_BYTE}; end
			default: keep = 32'hffffffff;
		endcase
		last_w = last_w | (msg.data_word & keep);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FE_IDLE:
				if (msg.valid && !q_full && msg.last_word)
					state_d = (fill_q == 4'd13 && nb != 3'd4) ? FE_LEN_HI : FE_PAD;
			FE_PAD:
				if (!q_full && fill_q == 4'd13) state_d = FE_LEN_HI;
			FE_LEN_HI:
				if (!q_full) state_d = FE_LEN_LO;
			FE_LEN_LO:
				if (!q_full) state_d = FE_IDLE;
			default: state_d = FE_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		msg.ready = 1'b0;
		q_push = 1'b0;
		w = '0;
		fin = 1'b0;
		unique case (state_q)
			FE_IDLE: begin
				msg.ready = !q_full;
				q_push = msg.valid && !q_full;
				w = msg.last_word ? last_w : msg.data_word;
			end
			FE_PAD: begin
				q_push = !q_full;
				w = two_q ? {PAD_BYTE, 24'h0} : '0;
			end
			FE_LEN_HI: begin
				q_push = !q_full;
				w = bits[63:32];
			end
			FE_LEN_LO: begin
				q_push = !q_full;
				w = bits[31:0];
				fin = 1'b1;
			end
			default: ;
		endcase
	end

	assign q_data = '{w: w, compress: (fill_q == 4'd15), finish: fin};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			bytes_q <= '0;
			fill_q <= '0;
			two_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_push) fill_q <= fill_q + 4'd1;
			if (state_q == FE_IDLE && q_push) begin
				bytes_q <= bytes_new;
				two_q <= msg.last_word && nb == 3'd4;
			end else if (state_q == FE_PAD && q_push) begin
				two_q <= 1'b0;
			end else if (state_q == FE_LEN_LO && q_push) begin
				bytes_q <= '0;
			end
		end
	end

endmodule

/* sv/sha_queue.sv */
// ----------------------------------------------------------------------------
// SHA-256 word queue
// Small FIFO between the front part and the compression engine.
// ----------------------------------------------------------------------------
module sha_queue #(
	parameter int unsigned DEPTH = sha_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sha_pkg::qent_t wdata,
	input  logic           push,
	output logic           full,
	output sha_pkg::qent_t rdata,
	input  logic           pop,
	output logic           empty
);
	import sha_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	qent_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (pop && !empty)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
		end
	end

endmodule

/* sv/sha_back.sv */
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Loads block words from the queue, runs 64 rounds at one per cycle, adds
// into the hash state and emits the digest after the final block.
// ----------------------------------------------------------------------------
module sha_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sha_pkg::qent_t q_data,
	input  logic           q_empty,
	output logic           q_pop,
	sha_dig_if.source      dig
);
	import sha_pkg::*;

	be_state_t state_q, state_d;
	word_t h_q [DIGEST_WORDS];
	word_t v_q [DIGEST_WORDS];
	word_t win_q [BLOCK_WORDS];
	logic [5:0] rnd_q;
	logic [2:0] idx_q;
	logic       fin_q;
	word_t x, y, s0, s1, wnew, t1, t2;
	logic last_round, take;

	assign take = !q_empty && state_q == BE_FILL;

	// Schedule: window is a shift line, win_q[0] is the current word
	always_comb begin
		x = win_q[1];
		y = win_q[14];
		s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
		s1 = rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10);
		wnew = win_q[0] + s0 + win_q[9] + s1;
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[rnd_q] + win_q[0];
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	assign last_round = (rnd_q == 6'd63);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BE_FILL: if (take && q_data.compress) state_d = BE_ROUND;
			BE_ROUND: if (last_round) state_d = BE_UPDATE;
			BE_UPDATE: state_d = fin_q ? BE_EMIT : BE_FILL;
			BE_EMIT: if (dig.ready && idx_q == 3'd7) state_d = BE_FILL;
			default: state_d = BE_FILL;
		endcase
	end

	// Outputs
	always_comb begin
		q_pop = take;
		dig.valid = (state_q == BE_EMIT);
		dig.digest_word = h_q[idx_q];
		dig.word_index = idx_q;
		dig.last_digest = (idx_q == 3'd7);
	end

	// Working variables and window
	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) win_q[i] <= win_q[i+1];
			win_q[BLOCK_WORDS-1] <= q_data.w;
			if (q_data.compress) for (int i = 0; i < DIGEST_WORDS; i++) v_q[i] <= h_q[i];
		end else if (state_q == BE_ROUND) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) win_q[i] <= win_q[i+1];
			win_q[BLOCK_WORDS-1] <= wnew;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// Control and hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BE_FILL;
			rnd_q <= '0;
			idx_q <= '0;
			fin_q <= 1'b0;
			for (int i = 0; i < DIGEST_WORDS; i++) h_q[i] <= init_h(3'(i));
		end else begin
			state_q <= state_d;
			if (take && q_data.compress) begin
				fin_q <= q_data.finish;
				rnd_q <= '0;
			end
			if (state_q == BE_ROUND) rnd_q <= rnd_q + 6'd1;
			if (state_q == BE_UPDATE)
				for (int i = 0; i < DIGEST_WORDS; i++) h_q[i] <= h_q[i] + v_q[i];
			if (state_q == BE_EMIT && dig.ready) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7)
					for (int i = 0; i < DIGEST_WORDS; i++) h_q[i] <= init_h(3'(i));
			end
		end
	end

endmodule

/* sv/sha256_message_hasher_core.sv */
// ----------------------------------------------------------------------------
// SHA-256 message hasher core
// Streams message words in, pads the message and emits the 256-bit digest.
// ----------------------------------------------------------------------------
//   channel  dir  payload                                  handshake
//   msg      in   data_word[31:0] bytes_valid[2:0] last    valid/ready
//   dig      out  digest_word[31:0] word_index[2:0] last   valid/ready
//
// A 16-word block takes 16 queue words, then the 64 rounds and the hash update;
// the round loop limits the sustained word rate.
// The last word adds up to 18 padding/length words (one extra block) and
// 8 digest words. Reset clears all control and loads the initial hash.
// Input stalls when the word queue is full and while the front part queues
// padding and length words; output stalls hold the digest word and block
// the engine.
// ----------------------------------------------------------------------------
module sha256_message_hasher_core #(
	parameter int unsigned QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sha_msg_if.sink   msg,
	sha_dig_if.source dig
);
	import sha_pkg::*;

	qent_t fq_data, bq_data;
	logic  push, full, pop, empty;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n), .msg(msg),
		.q_data(fq_data), .q_push(push), .q_full(full)
	);

	sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .wdata(fq_data), .push(push), .full(full),
		.rdata(bq_data), .pop(pop), .empty(empty)
	);

	sha_back u_back (
		.clk(clk), .arst_n(arst_n), .q_data(bq_data), .q_empty(empty),
		.q_pop(pop), .dig(dig)
	);

endmodule

/* sim/sha256_message_hasher_core_tb.sv */
// ----------------------------------------------------------------------------
// SHA-256 message hasher core testbench
// Streams messages through the hasher and checks each digest word against a
// predictor that pads, compresses and finishes every message itself.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_message_hasher_core_tb;
	import sha_pkg::*;

	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  nbytes;
		logic        last;
	} msg_word_t;

	typedef struct packed {
		logic [31:0] digest;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic clk;
	logic arst_n;

	sha_msg_if msg ();
	sha_dig_if dig ();

	sha256_message_hasher_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.dig    (dig)
	);

	// predictor state
	logic [31:0] hash_h [8];
	logic [31:0] blk [16];
	logic [60:0] msg_bytes;
	int          blk_fill;

	msg_word_t    word_q [$];
	digest_word_t digest_q [$];
	int           src_idle_pct;
	int           snk_stall_pct;
	bit           hold_src;
	int           mismatches;

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wr, t1, t2, x, y;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		for (int i = 0; i < 8; i++) v[i] = hash_h[i];
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wr = w[r];
			end else begin
				x = w[(r - 15) & 15];
				y = w[(r - 2) & 15];
				wr = w[r & 15] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + w[(r - 7) & 15]
					+ (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
				w[r & 15] = wr;
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + wr;
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int i = 7; i > 0; i--) v[i] = v[i - 1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_h[i] = hash_h[i] + v[i];
	endtask

	task automatic store_word(logic [31:0] w);
		blk[blk_fill] = w;
		blk_fill++;
		if (blk_fill == 16) begin
			compress();
			blk_fill = 0;
		end
	endtask

	task automatic reset_hash();
		for (int i = 0; i < 8; i++) hash_h[i] = H_INIT[i];
		msg_bytes = '0;
		blk_fill  = 0;
	endtask

	// apply one accepted word; on the last word queue the eight digest words
	task automatic hash_word(msg_word_t m);
		int          nb;
		logic [31:0] keep;
		logic [63:0] bits;
		digest_word_t d;
		if (!m.last) begin
			msg_bytes = msg_bytes + 61'd4;
			store_word(m.data);
			return;
		end
		nb = (m.nbytes > 4) ? 4 : int'(m.nbytes);
		msg_bytes = msg_bytes + 61'(nb);
		if (nb == 4) begin
			store_word(m.data);
			store_word(32'h8000_0000);
		end else begin
			keep = (nb == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * nb));
			store_word((m.data & keep) | (32'h80 << (24 - 8 * nb)));
		end
		// no room left for the length: zero fill one extra block
		if (blk_fill > 14)
			while (blk_fill != 0) store_word(32'h0);
		while (blk_fill < 14) store_word(32'h0);
		bits = {msg_bytes, 3'b000};
		store_word(bits[63:32]);
		store_word(bits[31:0]);
		for (int k = 0; k < 8; k++) begin
			d.digest = hash_h[k];
			d.index  = 3'(k);
			d.last   = (k == 7);
			digest_q = {digest_q, d};
		end
		reset_hash();
	endtask

	task automatic add_word(logic [31:0] data, logic [2:0] nb, logic last);
		msg_word_t m;
		m.data   = data;
		m.nbytes = nb;
		m.last   = last;
		word_q = {word_q, m};
	endtask

	// message of n full words followed by a last word
	task automatic add_message(int n, logic [2:0] nb, bit rnd);
		for (int i = 0; i < n; i++)
			add_word(rnd ? $urandom : 32'h6162_6364 + 32'(i), 3'($urandom_range(0, 7)), 1'b0);
		add_word(rnd ? $urandom : 32'h6162_6300, nb, 1'b1);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// time limit
	initial begin
		#30ms;
		$display("Some tests failed");
		$finish;
	end

	// word driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg.valid       <= 1'b0;
			msg.data_word   <= '0;
			msg.bytes_valid <= '0;
			msg.last_word   <= 1'b0;
		end else begin
			if (msg.valid && msg.ready) begin
				hash_word({msg.data_word, msg.bytes_valid, msg.last_word});
				void'(word_q.pop_front());
			end
			if (msg.valid && !msg.ready) begin
				// hold the word until taken
			end else if (word_q.size() > 0 && !hold_src
				&& $urandom_range(0, 99) >= src_idle_pct) begin
				msg.valid       <= 1'b1;
				msg.data_word   <= word_q[0].data;
				msg.bytes_valid <= word_q[0].nbytes;
				msg.last_word   <= word_q[0].last;
			end else begin
				msg.valid <= 1'b0;
			end
		end
	end

	// digest monitor and stall generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig.ready <= 1'b0;
		end else begin
			if (dig.valid && dig.ready) begin
				if (digest_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected digest word %h idx %0d",
							dig.digest_word, dig.word_index);
				end else begin
					if ({dig.digest_word, dig.word_index, dig.last_digest} != digest_q[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
								digest_q[0].digest, digest_q[0].index, digest_q[0].last,
								dig.digest_word, dig.word_index, dig.last_digest);
					end
					void'(digest_q.pop_front());
				end
			end
			dig.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// stimulus and end of run
	initial begin
		int lens [4];
		reset_hash();
		mismatches    = 0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		hold_src      = 1'b0;
		arst_n        = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty message, "abc", each byte count, saturated counts,
		// extremes of the data, and lengths around the edge of an extra padding block
		add_word(32'hffff_ffff, 3'd0, 1'b1);
		add_word(32'h6162_63ff, 3'd3, 1'b1);
		add_word(32'hffff_ffff, 3'd1, 1'b1);
		add_word(32'hffff_ffff, 3'd2, 1'b1);
		add_word(32'hffff_ffff, 3'd4, 1'b1);
		add_word(32'h0000_0000, 3'd7, 1'b1);
		add_word(32'hdead_beef, 3'd5, 1'b1);
		add_message(13, 3'd4, 1'b0);
		add_message(13, 3'd3, 1'b0);
		add_message(12, 3'd4, 1'b0);

		// pause until all digests are out
		hold_src = 1'b0;
		wait (word_q.size() == 0 && digest_q.size() == 0);
		hold_src = 1'b1;
		repeat (200) @(posedge clk);
		hold_src = 1'b0;

		// random messages over the source-idle and sink-stall phases
		lens = '{0, 72, 0, 36};
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct  = (ph == 1 || ph == 3) ? lens[ph] * (ph == 1 ? 1 : 2) : 0;
			snk_stall_pct = (ph == 2) ? 72 : (ph == 3 ? 36 : 0);
			if (ph == 3) src_idle_pct = 36;
			for (int n = 0; n < 5; n++) begin
				int len;
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 33)
					: $urandom_range(0, 15);
				add_message(len, 3'($urandom_range(0, 7)), 1'b1);
			end
			wait (word_q.size() == 0);
		end
		wait (digest_q.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && digest_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/sha_pkg.sv
sv/sha_msg_if.sv
sv/sha_dig_if.sv
sv/sha_front.sv
sv/sha_queue.sv
sv/sha_back.sv
sv/sha256_message_hasher_core.sv
sim/sha256_message_hasher_core_tb.sv
